// ===== rtl/core/ltc_pkg.sv =====
// Package for the lexer token classifier: entry kinds, class codes, the flag
// record and the operator symbol table with its lookup.
// No dependencies; every other file of the block but ltc_stream_if imports it.
package ltc_pkg;

    typedef enum logic [2:0] {
        KIND_WORD   = 3'd0,
        KIND_GROUP  = 3'd1,
        KIND_QUOTE  = 3'd2,
        KIND_SYMBOL = 3'd3,
        KIND_SPACE  = 3'd4
    } ltc_kind_t;

    typedef logic [5:0] ltc_code_t;

    localparam ltc_code_t CLS_NO_MATCH     = 6'd0;
    localparam ltc_code_t CLS_UNIDENTIFIED = 6'd1;
    localparam ltc_code_t CLS_CLASS        = 6'd2;
    localparam ltc_code_t CLS_ENUM         = 6'd3;
    localparam ltc_code_t CLS_SUBROUTINE   = 6'd4;
    localparam ltc_code_t CLS_INT_LITERAL  = 6'd5;
    localparam ltc_code_t CLS_PACKAGE      = 6'd6;
    localparam ltc_code_t CLS_PRIM_SIGNED  = 6'd7;
    localparam ltc_code_t CLS_PRIM_UNSIGN  = 6'd8;
    localparam ltc_code_t CLS_VARIABLE     = 6'd9;
    localparam ltc_code_t CLS_PAREN_OPEN   = 6'd10;
    localparam ltc_code_t CLS_PAREN_CLOSE  = 6'd11;
    localparam ltc_code_t CLS_BRACK_OPEN   = 6'd12;
    localparam ltc_code_t CLS_BRACK_CLOSE  = 6'd13;
    localparam ltc_code_t CLS_BRACE_OPEN   = 6'd14;
    localparam ltc_code_t CLS_BRACE_CLOSE  = 6'd15;
    localparam ltc_code_t CLS_SYM_BASE     = 6'd16;

    localparam int SYM_COUNT = 24;

    // Operator spellings, first byte in the upper half; a zero second byte
    // marks a one-byte operator. Entry i carries code CLS_SYM_BASE + i.
    localparam logic [15:0] SYM_TABLE [SYM_COUNT] = '{
        {8'h2B, 8'h00}, {8'h2B, 8'h2B}, {8'h2D, 8'h00}, {8'h2D, 8'h2D},
        {8'h2A, 8'h00}, {8'h2A, 8'h2A}, {8'h2F, 8'h00}, {8'h26, 8'h26},
        {8'h7C, 8'h7C}, {8'h26, 8'h00}, {8'h7C, 8'h00}, {8'h5E, 8'h00},
        {8'h21, 8'h00}, {8'h2E, 8'h2E}, {8'h2E, 8'h00}, {8'h2C, 8'h00},
        {8'h3A, 8'h3A}, {8'h3A, 8'h00}, {8'h3B, 8'h00}, {8'h3C, 8'h3C},
        {8'h3C, 8'h00}, {8'h3E, 8'h3E}, {8'h3E, 8'h00}, {8'h5C, 8'h00}
    };

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_S    = 8'h73;
    localparam logic [7:0] CH_LOWER_U    = 8'h75;
    localparam logic [7:0] CH_PAREN_OPEN = 8'h28;
    localparam logic [7:0] CH_PAREN_CLS  = 8'h29;
    localparam logic [7:0] CH_BRACK_OPEN = 8'h5B;
    localparam logic [7:0] CH_BRACK_CLS  = 8'h5D;
    localparam logic [7:0] CH_BRACE_OPEN = 8'h7B;
    localparam logic [7:0] CH_BRACE_CLS  = 8'h7D;

    // Running character-class flags; digit_only is bit 0.
    typedef struct packed {
        logic pre_digit;
        logic any_under;
        logic upper_seen;
        logic lower_seen;
        logic upper_only;
        logic lower_only;
        logic digit_only;
    } ltc_flags_t;

    localparam ltc_flags_t FLAGS_RESET = 7'h47;

    // Snapshot of a token handed from the accumulator to the classifier.
    typedef struct packed {
        logic [7:0] head;
        logic [7:0] tail;
        ltc_flags_t flags;
        logic [2:0] kind;
        logic [1:0] len_prev;
    } ltc_token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic ltc_code_t sym_lookup(input logic [7:0] a, input logic [7:0] b);
        ltc_code_t code;
        code = CLS_NO_MATCH;
        for (int i = 0; i < SYM_COUNT; i++) begin
            if (SYM_TABLE[i] == {a, b}) begin
                code = CLS_SYM_BASE + 6'(i);
            end
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/ltc_stream_if.sv =====
// Stream interfaces of the lexer token classifier: the character beat channel
// and the class result channel. Depends on nothing.
interface ltc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic [2:0] entry_kind;
    logic       last_char;

    modport source (output valid, output char_byte, output entry_kind,
                    output last_char, input ready);
    modport sink (input valid, input char_byte, input entry_kind,
                  input last_char, output ready);
endinterface

interface ltc_class_if;
    logic       valid;
    logic       ready;
    logic [5:0] token_class;

    modport source (output valid, output token_class, input ready);
    modport sink (input valid, input token_class, output ready);
endinterface

// ===== rtl/core/lexer_token_classifier_core.sv =====
// Lexer token classifier, top level: accumulator followed by classifier.
// Depends on ltc_pkg, ltc_stream_if, ltc_accum and ltc_classify.
//
// The block takes one character beat per clock, back to back, while the input is
// not stalled, and gives one class code per token, computed once its beat marked
// last is accepted. The running flag, length and first-byte registers are folded
// in the same cycle a beat is accepted, which sets the rate at one beat per cycle.
// A token's last beat loads the token snapshot register; the classifier then loads
// the class into the output register, which drives the result channel.
// Backpressure on the result channel stalls the input only once both of those
// registers are full.
module lexer_token_classifier_core (
    input  logic         clk,
    input  logic         rst_n,
    ltc_char_if.sink     chars,
    ltc_class_if.source  classes
);
    import ltc_pkg::*;

    logic       tok_valid;
    logic       tok_ready;
    ltc_token_t tok;

    ltc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_ready (tok_ready)
    );

    ltc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_ready (tok_ready),
        .classes   (classes)
    );

endmodule

// ===== rtl/core/ltc_accum.sv =====
// Token accumulator: folds each character beat into the first byte, length and
// flag registers, and registers a token snapshot on its last beat.
// Depends on ltc_pkg and ltc_char_if.
module ltc_accum (
    input  logic              clk,
    input  logic              rst_n,
    ltc_char_if.sink          chars,
    output logic              tok_valid,
    output ltc_pkg::ltc_token_t tok,
    input  logic              tok_ready
);
    import ltc_pkg::*;

    logic [7:0] first_reg, first_next;
    logic [1:0] len_reg, len_next;
    ltc_flags_t flags_reg, flags_next;
    logic       tok_valid_reg, tok_valid_next;
    ltc_token_t tok_reg, tok_next;

    logic       accept;
    logic [7:0] c;
    ltc_flags_t folded;
    logic [7:0] head;

    assign c      = chars.char_byte;
    assign accept = chars.valid && chars.ready;
    assign chars.ready = !tok_valid_reg || tok_ready;

    always_comb
    begin
        folded.digit_only = flags_reg.digit_only && is_digit(c);
        folded.lower_only = flags_reg.lower_only && is_lower(c);
        folded.upper_only = flags_reg.upper_only && is_upper(c);
        folded.lower_seen = flags_reg.lower_seen || is_lower(c);
        folded.upper_seen = flags_reg.upper_seen || is_upper(c);
        folded.any_under  = flags_reg.any_under || (c == CH_UNDERSCORE);
        folded.pre_digit  = flags_reg.digit_only;
        head = (len_reg == 2'd0) ? c : first_reg;

        first_next     = first_reg;
        len_next       = len_reg;
        flags_next     = flags_reg;
        tok_valid_next = tok_valid_reg;
        tok_next       = tok_reg;

        if (tok_ready) begin
            tok_valid_next = 1'b0;
        end
        if (accept) begin
            if (chars.last_char) begin
                // Token complete: hand it on and start the next one clean.
                first_next     = 8'd0;
                len_next       = 2'd0;
                flags_next     = FLAGS_RESET;
                tok_valid_next = 1'b1;
                tok_next.head     = head;
                tok_next.tail     = c;
                tok_next.flags    = folded;
                tok_next.kind     = chars.entry_kind;
                tok_next.len_prev = len_reg;
            end
            else begin
                first_next = head;
                flags_next = folded;
                if (len_reg != 2'd3) begin
                    len_next = len_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            first_reg     <= 8'd0;
            len_reg       <= 2'd0;
            flags_reg     <= FLAGS_RESET;
            tok_valid_reg <= 1'b0;
        end
        else begin
            first_reg     <= first_next;
            len_reg       <= len_next;
            flags_reg     <= flags_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chars.last_char) |=> (len_reg == 2'd0 && flags_reg == FLAGS_RESET))
        else $error("token state not cleared after last beat");

    a_len_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !chars.last_char && len_reg != 2'd3) |=> (len_reg == $past(len_reg) + 2'd1))
        else $error("length count did not advance");

    a_lower_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (flags_reg.lower_seen && !(accept && chars.last_char)) |=> flags_reg.lower_seen)
        else $error("lower-seen flag dropped inside a token");

    a_snapshot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid_reg && !tok_ready) |=> (tok_valid_reg && $stable(tok_reg)))
        else $error("token snapshot lost while stalled");
`endif

endmodule

// ===== rtl/core/ltc_classify.sv =====
// Token classifier stage: turns a registered token snapshot into a class code
// and holds it in the output register. Depends on ltc_pkg and ltc_class_if.
module ltc_classify (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  ltc_pkg::ltc_token_t tok,
    output logic              tok_ready,
    ltc_class_if.source       classes
);
    import ltc_pkg::*;

    logic      out_valid_reg, out_valid_next;
    ltc_code_t code_reg, code_next;
    ltc_code_t code;
    ltc_code_t word_code;
    ltc_code_t group_code;
    logic [7:0] sym_b;
    logic up0, lo0, lo_n, und, anyl, anyu;

    assign tok_ready = !out_valid_reg || classes.ready;

    always_comb
    begin
        up0  = is_upper(tok.head);
        lo0  = is_lower(tok.head);
        lo_n = is_lower(tok.tail);
        und  = tok.flags.any_under;
        anyl = tok.flags.lower_seen;
        anyu = tok.flags.upper_seen;

        // Naming-convention rules, highest priority first.
        if (up0 && !und && lo_n) begin
            word_code = CLS_CLASS;
        end
        else if ((up0 && und && !anyl) || tok.flags.upper_only) begin
            word_code = CLS_ENUM;
        end
        else if (lo0 && !und && lo_n && anyu) begin
            word_code = CLS_SUBROUTINE;
        end
        else if (tok.flags.digit_only) begin
            word_code = CLS_INT_LITERAL;
        end
        else if (tok.flags.lower_only) begin
            word_code = CLS_PACKAGE;
        end
        else if (tok.tail == CH_LOWER_S && tok.flags.pre_digit) begin
            word_code = CLS_PRIM_SIGNED;
        end
        else if (tok.tail == CH_LOWER_U && tok.flags.pre_digit) begin
            word_code = CLS_PRIM_UNSIGN;
        end
        else if (und && !anyu && anyl) begin
            word_code = CLS_VARIABLE;
        end
        else begin
            word_code = CLS_NO_MATCH;
        end

        case (tok.head)
            CH_PAREN_OPEN: group_code = CLS_PAREN_OPEN;
            CH_PAREN_CLS:  group_code = CLS_PAREN_CLOSE;
            CH_BRACK_OPEN: group_code = CLS_BRACK_OPEN;
            CH_BRACK_CLS:  group_code = CLS_BRACK_CLOSE;
            CH_BRACE_OPEN: group_code = CLS_BRACE_OPEN;
            CH_BRACE_CLS:  group_code = CLS_BRACE_CLOSE;
            default:       group_code = CLS_NO_MATCH;
        endcase

        // A one-byte token compares against a zero second byte.
        sym_b = (tok.len_prev == 2'd0) ? 8'd0 : tok.tail;

        case (tok.kind)
            KIND_WORD:   code = word_code;
            KIND_GROUP:  code = group_code;
            KIND_SYMBOL: code = tok.len_prev[1] ? CLS_NO_MATCH : sym_lookup(tok.head, sym_b);
            default:     code = CLS_UNIDENTIFIED;
        endcase

        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        if (classes.ready) begin
            out_valid_next = 1'b0;
        end
        if (tok_valid && tok_ready) begin
            out_valid_next = 1'b1;
            code_next      = code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign classes.valid       = out_valid_reg;
    assign classes.token_class = code_reg;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for lexer_token_classifier_core: drives character beats token by token,
// predicts or pins each token's class and checks every class beat in order.
// Depends on ltc_pkg, the ltc_char_if and ltc_class_if interfaces and the core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ltc_pkg::*;

    localparam int RANDOM_BEATS = 400;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PREDICT      = -1;
    localparam logic [2:0] KIND_SPARE = 3'd7;

    typedef enum logic [5:0] {
        SYM_PLUS = 6'd16, SYM_INCR, SYM_MINUS, SYM_DECR, SYM_STAR, SYM_POWER,
        SYM_SLASH, SYM_LAND, SYM_LOR, SYM_AMP, SYM_BAR, SYM_CARET,
        SYM_BANG, SYM_RANGE, SYM_DOT, SYM_COMMA, SYM_SCOPE, SYM_COLON,
        SYM_SEMI, SYM_SHL, SYM_LT, SYM_SHR, SYM_GT, SYM_BSLASH
    } op_code_t;

    typedef enum {POOL_DIGIT, POOL_LOWER, POOL_UPPER, POOL_UNDER, POOL_ANY} char_pool_t;

    typedef enum {
        STYLE_PASCAL, STYLE_SHOUT, STYLE_CAMEL, STYLE_NUMBER,
        STYLE_LOWER, STYLE_TYPED_NUM, STYLE_SNAKE, STYLE_MIXED
    } word_style_t;

    // Token text is right-aligned: the last character sits in the low byte.
    typedef struct packed {
        logic [31:0] text;
        int          len;
        logic [2:0]  kind;
        int          pinned;
    } token_row_t;

    token_row_t directed_tokens [18] = '{
        '{"Ab",   2, KIND_WORD,   CLS_CLASS},
        '{"A_B",  3, KIND_WORD,   CLS_ENUM},
        '{"aBc",  3, KIND_WORD,   CLS_SUBROUTINE},
        '{"9",    1, KIND_WORD,   CLS_INT_LITERAL},
        '{"z",    1, KIND_WORD,   CLS_PACKAGE},
        '{"8s",   2, KIND_WORD,   CLS_PRIM_SIGNED},
        '{"0u",   2, KIND_WORD,   CLS_PRIM_UNSIGN},
        '{"a_b",  3, KIND_WORD,   CLS_VARIABLE},
        '{32'hFF, 1, KIND_WORD,   CLS_NO_MATCH},
        '{"(",    1, KIND_GROUP,  CLS_PAREN_OPEN},
        '{"x",    1, KIND_GROUP,  CLS_NO_MATCH},
        '{"**",   2, KIND_SYMBOL, PREDICT},
        '{"<",    1, KIND_SYMBOL, PREDICT},
        '{"+++",  3, KIND_SYMBOL, CLS_NO_MATCH},
        '{"\\",   1, KIND_SYMBOL, PREDICT},
        '{"\"",   1, KIND_QUOTE,  CLS_UNIDENTIFIED},
        '{32'h00, 1, KIND_SPACE,  CLS_UNIDENTIFIED},
        '{"?",    1, KIND_SPARE,  CLS_UNIDENTIFIED}
    };

    localparam logic [7:0] BRACKETS [6] = '{"(", ")", "[", "]", "{", "}"};
    localparam logic [7:0] OP_CHARS [15] = '{
        "+", "-", "*", "/", "&", "|", "^", "!", ".", ",", ":", ";", "<", ">", "\\"
    };

    logic clk;
    logic rst_n;

    ltc_char_if  chars_if ();
    ltc_class_if classes_if ();

    lexer_token_classifier_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .classes (classes_if)
    );

    // Running picture of the token being assembled.
    logic [7:0] tok_head  = '0;
    logic [1:0] tok_len   = '0;
    ltc_flags_t tok_flags = FLAGS_RESET;

    ltc_code_t  expected_classes [$];
    logic [7:0] tok_chars [$];
    logic [2:0] tok_kinds [$];

    int         pinned_code = PREDICT;
    int         mismatches  = 0;
    int         beats_sent  = 0;
    bit         idle_on     = 1'b0;

    logic [7:0] beat_char;
    logic [7:0] beat_head;
    ltc_flags_t beat_flags;
    ltc_code_t  beat_code;
    ltc_code_t  want_class;
    logic       is_dig;
    logic       is_low;
    logic       is_up;

    function automatic ltc_code_t classify_token(input logic [2:0] kind,
                                                 input logic [7:0] head,
                                                 input logic [7:0] tail,
                                                 input int total,
                                                 input ltc_flags_t f);
        logic       up0;
        logic       lo0;
        logic       lo_tail;
        logic [7:0] second;
        ltc_code_t  code;
        up0     = head inside {["A":"Z"]};
        lo0     = head inside {["a":"z"]};
        lo_tail = tail inside {["a":"z"]};
        // A one-byte operator is matched with a zero second byte.
        second  = (total == 1) ? 8'h00 : tail;
        code    = CLS_NO_MATCH;
        case (kind)
            KIND_WORD:
            begin
                if (up0 && !f.any_under && lo_tail)
                    code = CLS_CLASS;
                else if ((up0 && f.any_under && !f.lower_seen) || f.upper_only)
                    code = CLS_ENUM;
                else if (lo0 && !f.any_under && lo_tail && f.upper_seen)
                    code = CLS_SUBROUTINE;
                else if (f.digit_only)
                    code = CLS_INT_LITERAL;
                else if (f.lower_only)
                    code = CLS_PACKAGE;
                else if (tail == CH_LOWER_S && f.pre_digit)
                    code = CLS_PRIM_SIGNED;
                else if (tail == CH_LOWER_U && f.pre_digit)
                    code = CLS_PRIM_UNSIGN;
                else if (f.any_under && !f.upper_seen && f.lower_seen)
                    code = CLS_VARIABLE;
            end
            KIND_GROUP:
            begin
                case (head)
                    CH_PAREN_OPEN: code = CLS_PAREN_OPEN;
                    CH_PAREN_CLS:  code = CLS_PAREN_CLOSE;
                    CH_BRACK_OPEN: code = CLS_BRACK_OPEN;
                    CH_BRACK_CLS:  code = CLS_BRACK_CLOSE;
                    CH_BRACE_OPEN: code = CLS_BRACE_OPEN;
                    CH_BRACE_CLS:  code = CLS_BRACE_CLOSE;
                    default:       code = CLS_NO_MATCH;
                endcase
            end
            KIND_SYMBOL:
            begin
                if (total <= 2)
                begin
                    case ({head, second})
                        {"+", 8'h00}:  code = SYM_PLUS;
                        "++":          code = SYM_INCR;
                        {"-", 8'h00}:  code = SYM_MINUS;
                        "--":          code = SYM_DECR;
                        {"*", 8'h00}:  code = SYM_STAR;
                        "**":          code = SYM_POWER;
                        {"/", 8'h00}:  code = SYM_SLASH;
                        "&&":          code = SYM_LAND;
                        "||":          code = SYM_LOR;
                        {"&", 8'h00}:  code = SYM_AMP;
                        {"|", 8'h00}:  code = SYM_BAR;
                        {"^", 8'h00}:  code = SYM_CARET;
                        {"!", 8'h00}:  code = SYM_BANG;
                        "..":          code = SYM_RANGE;
                        {".", 8'h00}:  code = SYM_DOT;
                        {",", 8'h00}:  code = SYM_COMMA;
                        "::":          code = SYM_SCOPE;
                        {":", 8'h00}:  code = SYM_COLON;
                        {";", 8'h00}:  code = SYM_SEMI;
                        "<<":          code = SYM_SHL;
                        {"<", 8'h00}:  code = SYM_LT;
                        ">>":          code = SYM_SHR;
                        {">", 8'h00}:  code = SYM_GT;
                        {"\\", 8'h00}: code = SYM_BSLASH;
                        default:       code = CLS_NO_MATCH;
                    endcase
                end
            end
            default:
                code = CLS_UNIDENTIFIED;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] char_from(input char_pool_t pool);
        case (pool)
            POOL_DIGIT: return 8'($urandom_range("0", "9"));
            POOL_LOWER: return 8'($urandom_range("a", "z"));
            POOL_UPPER: return 8'($urandom_range("A", "Z"));
            POOL_UNDER: return CH_UNDERSCORE;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sends the token held in tok_chars/tok_kinds, marking its final beat.
    task automatic send_token();
        for (int i = 0; i < tok_chars.size(); i++)
        begin
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                chars_if.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            chars_if.valid      <= 1'b1;
            chars_if.char_byte  <= tok_chars[i];
            chars_if.entry_kind <= tok_kinds[i];
            chars_if.last_char  <= (i == tok_chars.size() - 1);
            @(posedge clk);
            while (!chars_if.ready)
                @(posedge clk);
            @(negedge clk);
            beats_sent++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Prediction on every accepted character beat, checking on every class beat.
    always @(posedge clk)
    begin
        if (chars_if.valid && chars_if.ready)
        begin
            beat_char = chars_if.char_byte;
            is_dig    = beat_char inside {["0":"9"]};
            is_low    = beat_char inside {["a":"z"]};
            is_up     = beat_char inside {["A":"Z"]};
            beat_flags.digit_only = tok_flags.digit_only & is_dig;
            beat_flags.lower_only = tok_flags.lower_only & is_low;
            beat_flags.upper_only = tok_flags.upper_only & is_up;
            beat_flags.lower_seen = tok_flags.lower_seen | is_low;
            beat_flags.upper_seen = tok_flags.upper_seen | is_up;
            beat_flags.any_under  = tok_flags.any_under | (beat_char == CH_UNDERSCORE);
            beat_flags.pre_digit  = tok_flags.digit_only;
            beat_head = (tok_len == 2'd0) ? beat_char : tok_head;
            if (chars_if.last_char)
            begin
                beat_code = classify_token(chars_if.entry_kind, beat_head, beat_char,
                                           int'(tok_len) + 1, beat_flags);
                if (pinned_code != PREDICT)
                    beat_code = ltc_code_t'(pinned_code);
                expected_classes.push_back(beat_code);
                tok_head  = '0;
                tok_len   = '0;
                tok_flags = FLAGS_RESET;
            end
            else
            begin
                tok_head  = beat_head;
                tok_len   = (tok_len == 2'd3) ? tok_len : tok_len + 2'd1;
                tok_flags = beat_flags;
            end
        end

        if (classes_if.valid && classes_if.ready)
        begin
            if (expected_classes.size() == 0)
            begin
                $display("%0t: class beat %0d arrived with nothing pending", $time,
                         classes_if.token_class);
                mismatches++;
            end
            else
            begin
                want_class = expected_classes.pop_front();
                if (classes_if.token_class !== want_class)
                begin
                    $display("%0t: token_class mismatch, expected %0d actual %0d", $time,
                             want_class, classes_if.token_class);
                    mismatches++;
                end
            end
        end
    end

    // Result side: random stall bursts while idling is enabled.
    initial
    begin
        classes_if.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                classes_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                classes_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((chars_if.valid && chars_if.ready) || (classes_if.valid && classes_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        token_row_t  row;
        word_style_t style;
        char_pool_t  pool;
        logic [2:0]  kind;
        int          len;
        int          pick;
        bit          paused;

        chars_if.valid      = 1'b0;
        chars_if.char_byte  = '0;
        chars_if.entry_kind = KIND_WORD;
        chars_if.last_char  = 1'b0;
        rst_n  = 1'b0;
        paused = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        idle_on = 1'b1;

        foreach (directed_tokens[r])
        begin
            row = directed_tokens[r];
            tok_chars.delete();
            tok_kinds.delete();
            for (int i = 0; i < row.len; i++)
            begin
                tok_chars.push_back(row.text[8 * (row.len - 1 - i) +: 8]);
                tok_kinds.push_back(row.kind);
            end
            pinned_code = row.pinned;
            send_token();
        end

        pinned_code = PREDICT;
        beats_sent  = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            // Idling comes and goes in phases and stops for the final stretch.
            idle_on = (beats_sent < RANDOM_BEATS - 60) && ((beats_sent / 70) % 3 != 2);

            // Once, mid-run, hold the sender until every class has come back.
            if (!paused && beats_sent >= RANDOM_BEATS / 2)
            begin
                paused = 1'b1;
                chars_if.valid <= 1'b0;
                wait (expected_classes.size() == 0);
                @(negedge clk);
            end

            tok_chars.delete();
            tok_kinds.delete();
            pick = $urandom_range(0, 19);
            if (pick < 9)
            begin
                style = word_style_t'($urandom_range(0, 7));
                len   = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    case (style)
                        STYLE_PASCAL:
                            pool = (i == 0) ? POOL_UPPER : POOL_LOWER;
                        STYLE_SHOUT:
                            pool = (i > 0 && $urandom_range(0, 2) == 0) ? POOL_UNDER
                                                                       : POOL_UPPER;
                        STYLE_CAMEL:
                            pool = (i == 0 || i == len - 1 || $urandom_range(0, 1) == 0)
                                   ? POOL_LOWER : POOL_UPPER;
                        STYLE_NUMBER, STYLE_TYPED_NUM:
                            pool = POOL_DIGIT;
                        STYLE_LOWER:
                            pool = POOL_LOWER;
                        STYLE_SNAKE:
                            pool = (i > 0 && $urandom_range(0, 2) == 0) ? POOL_UNDER
                                                                       : POOL_LOWER;
                        default:
                            pool = char_pool_t'($urandom_range(0, 4));
                    endcase
                    if ($urandom_range(0, 9) == 0)
                        pool = char_pool_t'($urandom_range(0, 4));
                    tok_chars.push_back(char_from(pool));
                    tok_kinds.push_back(KIND_WORD);
                end
                if (style == STYLE_TYPED_NUM)
                    tok_chars[len - 1] = $urandom_range(0, 1) ? CH_LOWER_S : CH_LOWER_U;
            end
            else if (pick < 11)
            begin
                len = ($urandom_range(0, 7) == 0) ? 2 : 1;
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        tok_chars.push_back(char_from(POOL_ANY));
                    else
                        tok_chars.push_back(BRACKETS[$urandom_range(0, 5)]);
                    tok_kinds.push_back(KIND_GROUP);
                end
            end
            else if (pick < 16)
            begin
                pick = $urandom_range(0, 9);
                len  = (pick < 5) ? 1 : (pick < 9) ? 2 : $urandom_range(3, 4);
                for (int i = 0; i < len; i++)
                begin
                    if (i > 0 && $urandom_range(0, 1) == 1)
                        tok_chars.push_back(tok_chars[0]);
                    else if ($urandom_range(0, 9) == 0)
                        tok_chars.push_back(char_from(POOL_ANY));
                    else
                        tok_chars.push_back(OP_CHARS[$urandom_range(0, 14)]);
                    tok_kinds.push_back(KIND_SYMBOL);
                end
            end
            else if (pick < 18)
            begin
                pick = $urandom_range(0, 4);
                kind = (pick == 0) ? 3'(KIND_QUOTE) :
                       (pick == 1) ? 3'(KIND_SPACE) :
                       3'(KIND_SPACE) + 3'($urandom_range(1, 3));
                len  = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                begin
                    tok_chars.push_back(char_from(POOL_ANY));
                    tok_kinds.push_back(kind);
                end
            end
            else
            begin
                // Noise: the entry kind may change from beat to beat.
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                begin
                    tok_chars.push_back(char_from(POOL_ANY));
                    tok_kinds.push_back(3'($urandom_range(0, 7)));
                end
            end
            send_token();
        end

        chars_if.valid <= 1'b0;
        wait (expected_classes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ltc_pkg.sv
rtl/core/ltc_stream_if.sv
rtl/core/ltc_accum.sv
rtl/core/ltc_classify.sv
rtl/core/lexer_token_classifier_core.sv
bench/tb_top.sv
